### hw/rtl/hspd_pkg.sv
// ----------------------------------------------------------------------------
// hspd_pkg
// Shared types, operation codes and transition table of the hall decoder.
// ----------------------------------------------------------------------------
package hspd_pkg;

  localparam int unsigned HallW = 3;
  localparam int unsigned PosW  = 64;
  localparam int unsigned NumCodes = 6;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_INIT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TRANS_CW,
    TRANS_CCW,
    TRANS_BAD
  } trans_e;

  localparam logic DirCw  = 1'b0;
  localparam logic DirCcw = 1'b1;

  // Transition codes: previous sample in the upper three bits, current below.
  localparam logic [5:0] CwCodes [NumCodes] = '{
    6'h29, 6'h0B, 6'h1A, 6'h16, 6'h34, 6'h25
  };
  localparam logic [5:0] CcwCodes [NumCodes] = '{
    6'h19, 6'h13, 6'h32, 6'h26, 6'h2C, 6'h0D
  };

  // One item as it leaves the input register.
  typedef struct packed {
    op_e                      op;
    logic [HallW-1:0]         hall_bits;
    logic signed [PosW-1:0]   load_value;
  } item_t;

  // Decoder state after an item; also the payload of one result.
  typedef struct packed {
    logic                     direction;
    logic                     error_flag;
    logic signed [PosW-1:0]   position;
  } result_t;

  function automatic trans_e hspd_classify(input logic [5:0] code);
    trans_e cls;
    cls = TRANS_BAD;
    for (int i = 0; i < NumCodes; i++) begin
      if (CwCodes[i] == code) begin
        cls = TRANS_CW;
      end
      if (CcwCodes[i] == code) begin
        cls = TRANS_CCW;
      end
    end
    return cls;
  endfunction

endpackage

### hw/rtl/hspd_core.sv
// ----------------------------------------------------------------------------
// hspd_core
// Decoder state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module hspd_core import hspd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,     // apply item_i this cycle
  input  item_t   item_i,
  output result_t result_o    // state after item_i
);

  logic [HallW-1:0]       prev_q, prev_d;
  logic                   dir_q, dir_d;
  logic                   err_q, err_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  trans_e                 cls;

  assign cls = hspd_classify({prev_q, item_i.hall_bits});

  always_comb begin
    prev_d = prev_q;
    dir_d  = dir_q;
    err_d  = err_q;
    pos_d  = pos_q;
    case (item_i.op)
      OP_SAMPLE: begin
        if (item_i.hall_bits != prev_q) begin
          case (cls)
            TRANS_CW:  dir_d = DirCw;
            TRANS_CCW: dir_d = DirCcw;
            default:   err_d = 1'b1;
          endcase
          // step by the direction after this edge, kept on a bad transition
          pos_d  = (dir_d == DirCcw) ? pos_q + PosW'(1) : pos_q - PosW'(1);
          prev_d = item_i.hall_bits;
        end
      end
      OP_LOAD:  pos_d = item_i.load_value;
      OP_CLEAR: err_d = 1'b0;
      OP_INIT: begin
        dir_d  = DirCw;
        err_d  = 1'b0;
        pos_d  = '0;
        prev_d = item_i.hall_bits;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      dir_q  <= DirCw;
      err_q  <= 1'b0;
      pos_q  <= '0;
    end else if (step_i) begin
      prev_q <= prev_d;
      dir_q  <= dir_d;
      err_q  <= err_d;
      pos_q  <= pos_d;
    end
  end

  assign result_o.direction  = dir_d;
  assign result_o.error_flag = err_d;
  assign result_o.position   = pos_d;

`ifndef SYNTHESIS
  // Only clear or initialize drops the sticky error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !(step_i && (item_i.op == OP_CLEAR || item_i.op == OP_INIT)) |=> err_q)
    else $error("hspd_core: error flag dropped without clear");

  // Initialize leaves a clean, zeroed state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.op == OP_INIT |=> pos_q == '0 && !err_q && dir_q == DirCw)
    else $error("hspd_core: initialize left state behind");

  // A repeated sample moves nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.op == OP_SAMPLE && item_i.hall_bits == prev_q
    |=> $stable(pos_q) && $stable(dir_q) && $stable(err_q))
    else $error("hspd_core: unchanged sample altered state");
`endif

endmodule

### hw/rtl/hall_sensor_position_decoder.sv
// Pipeline: an item passes through the input register, then the result register;
//   the state update in hspd_core is combinational between the two.
// Throughput: one item per cycle while the result stream is not back-pressured,
//   with the table lookup and 64-bit position increment in hspd_core combinational.
// Reset (rst_ni low, asynchronous): both pipeline stages empty, position 0,
//   direction clockwise, error flag clear, previous sample 0.
// ----------------------------------------------------------------------------
// hall_sensor_position_decoder
// Three-phase hall sensor decoder: direction, sticky error and 64-bit
// position, one result per operation item.
// ----------------------------------------------------------------------------
module hall_sensor_position_decoder import hspd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [2:0] hall_bits, [66:3] load_value, zero pad
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [0] direction, [1] error_flag,
                                        // [65:2] position, zero pad
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;   // item in the input register moves into the result register
  result_t core_res;

  // Advance when the result register is free or being drained this cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register: take a transfer whenever the stage is free or moving on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.op         <= op_e'(s_axis_tuser_i);
      in_item_q.hall_bits  <= s_axis_tdata_i[2:0];
      in_item_q.load_value <= s_axis_tdata_i[66:3];
    end
  end

  // Decoder state and update: commits only when the item advances.
  hspd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  // Result register: hold until the downstream side takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.position, out_q.error_flag, out_q.direction};

`ifndef SYNTHESIS
  // A full input stage refuses new items only because the result is stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("hspd: input stalled without downstream back-pressure");

  // Every advanced item shows up as a valid result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("hspd: advanced item lost");
`endif

endmodule
